// ===== hdl/bbq_pkg.sv =====
package bbq_pkg;
  localparam int LEVELS_DEF = 4;
  localparam int BANKS_DEF = 4;
  localparam int SAMPLE_W = 24;
  localparam int WORD_W = 16;
  localparam int SET_W = 12;
  localparam int Y_W = 38;
  localparam int ACC_W = 64;
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;
  localparam int SLOT_B0 = 0;
  localparam int SLOT_SET = 5;

  function automatic logic signed [16:0] word_b(input logic [15:0] w);
    logic signed [16:0] m;
    m = $signed({2'b00, w[14:0]});
    return w[15] ? -m : m;
  endfunction

  function automatic logic signed [16:0] word_a(input logic [15:0] w);
    logic signed [16:0] m;
    m = $signed({2'b00, w[14:0]});
    return w[15] ? m : -m;
  endfunction
endpackage

// ===== hdl/bbq_stream_if.sv =====
interface bbq_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/banked_biquad_cascade_filter_core.sv =====
// banked biquad cascade filter core
// in channel (sink): payload {func, bank, word_index, para_word, sample, frame_end},
//   func at the msb. a load transfer (func=1) writes one coefficient or
//   setting word and gives no result. a filter transfer (func=0) gives one
//   result on out: payload {filtered, frame_last}.
// one item at a time: a load is done in the idle state; a sample is worked
// by the shared multiplier walking five products per level, with two read
// steps before them, one limit step and one write back per level, then two
// gain steps and the output step.
// out.valid rises at the output step; in.ready is back high in the same
// cycle.
// after reset a clearing pass over the BANKS*LEVELS*8 coefficient words zeroes
// the history and coefficient memories; no input is taken until it finishes.
// results sit in an output register; the core takes the next item while a
// result waits, but does not finish a sample until out is free, so a
// stalled receiver holds in.ready low at the output step.
// reset clears control state; bank setting words are flip-flops.
module banked_biquad_cascade_filter_core
  import bbq_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF,
  parameter int BANKS = BANKS_DEF
) (
  input logic clk,
  input logic rst,
  bbq_stream_if.sink in,
  bbq_stream_if.source out
);
  localparam int HD = BANKS * LEVELS * 2;
  localparam int HA = $clog2(HD) > 0 ? $clog2(HD) : 1;
  localparam int CD = BANKS * LEVELS * 8;
  localparam int CA = $clog2(CD);
  localparam int BW = BANKS > 1 ? $clog2(BANKS) : 1;
  localparam int LW = LEVELS > 1 ? $clog2(LEVELS) : 1;
  localparam logic [4:0] ST_CLR = 5'd0, ST_IDLE = 5'd1, ST_RD = 5'd2,
    ST_RD2 = 5'd3, ST_MAC = 5'd4, ST_LIM = 5'd5, ST_WB = 5'd6,
    ST_G1 = 5'd7, ST_G2 = 5'd8, ST_OUT = 5'd9;

  logic [4:0] state;
  logic [CA:0] clr_cnt;
  // input item fields
  logic func_i; logic [1:0] bank_i; logic [4:0] widx_i;
  logic [15:0] pword_i; logic signed [23:0] samp_i; logic fend_i;
  assign {func_i, bank_i, widx_i, pword_i, samp_i, fend_i} = in.data;

  logic [SET_W-1:0] setting [BANKS];
  logic [BW-1:0] bnk;
  logic [LW-1:0] lvl;
  logic [2:0] term;
  logic fend_r;
  logic signed [23:0] d;
  logic signed [ACC_W-1:0] accx, accy;
  logic signed [23:0] x1, x2;
  logic signed [Y_W-1:0] y1, y2;
  logic [15:0] cw;
  logic signed [ACC_W-1:0] prod;
  logic signed [Y_W-1:0] yf;
  logic signed [23:0] o_val;

  // memories: coefficients (8 slots per level) and x/y history (entry 0, 1)
  logic c_we; logic [CA-1:0] c_wa, c_ra; logic [15:0] c_wd, c_rd;
  logic h_we; logic [HA-1:0] h_wa, h_ra;
  logic [2*24+2*Y_W-1:0] h_wd, h_rd;
  bbq_ram #(.W(16), .D(CD)) u_coef (.clk, .we(c_we), .waddr(c_wa), .wdata(c_wd),
    .raddr(c_ra), .rdata(c_rd));
  bbq_ram #(.W(2*24+2*Y_W), .D(HD)) u_hist (.clk, .we(h_we), .waddr(h_wa),
    .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

  logic [HA-1:0] hidx;
  assign hidx = HA'(bnk * LEVELS + lvl);
  logic [CA-1:0] cbase;
  assign cbase = CA'((32'(bnk) * LEVELS + 32'(lvl)) * 8);

  // load decode: level = word_index / 6 by reciprocal multiply (exact for 0..31)
  logic [4:0] ld_lv; logic [2:0] ld_slot; logic [8:0] ld_prod;
  always_comb begin
    ld_prod = 9'(widx_i) * 9'd11;
    ld_lv = 5'(ld_prod[8:6]);
    ld_slot = 3'(widx_i - 5'(ld_lv * 5'd6));
  end

  assign in.ready = (state == ST_IDLE);
  logic in_xfer;
  assign in_xfer = in.valid && in.ready;

  logic dbl;
  assign dbl = setting[bnk][8];

  // product select: term 0..4 = b0*d, b1*x1, b2*x2, a1*y1, a2*y2
  logic signed [16:0] cs;
  logic signed [Y_W-1:0] op;
  always_comb begin
    cs = (term < 3'd3) ? word_b(cw) : word_a(cw);
    case (term)
      3'd0: op = Y_W'(d);
      3'd1: op = Y_W'(x1);
      3'd2: op = Y_W'(x2);
      3'd3: op = y1;
      default: op = y2;
    endcase
  end

  // one product per cycle, b2 and a2 doubled when the bank asks for it
  always_comb begin
    prod = ACC_W'(cs) * ACC_W'(op);
    if (dbl && (term == 3'd2 || term == 3'd4)) prod = prod <<< 1;
  end

  // limit and round
  logic signed [ACC_W-1:0] acc, lim;
  always_comb begin
    acc = accx * 8192 - accy;
    lim = 64'sd8388607 * 64'sd67108864;
    if (acc >= lim) begin
      o_val = 24'sd8388607; yf = Y_W'(64'sd8388607 * 8192);
    end else if (acc <= -lim) begin
      o_val = -24'sd8388606; yf = Y_W'(-64'sd8388606 * 8192);
    end else begin
      o_val = 24'((acc < 0) ? -((-acc) >>> 26) : (acc >>> 26));
      yf = Y_W'(acc >>> 13);
    end
  end

  // gain
  logic [2:0] base; logic [4:0] gsum; logic [3:0] sh;
  logic signed [ACC_W-1:0] gprod, gq;
  always_comb begin
    case (setting[bnk][2:0])
      3'd1: base = 3'd1;
      3'd2: base = 3'd2;
      3'd4: base = 3'd4;
      default: base = 3'd0;
    endcase
    gsum = {1'b0, setting[bnk][6:3]};
    sh = (setting[bnk][11] && setting[bnk][7]) ? 4'd13 :
         (setting[bnk][7] ? 4'd12 : 4'd10);
    gprod = ACC_W'(d) * ACC_W'($signed({1'b0, base})) * ACC_W'($signed({1'b0, gsum}));
    gq = (gprod < 0) ? -((-gprod) >>> sh) : (gprod >>> sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR; clr_cnt <= '0; out.valid <= 1'b0;
      for (int i = 0; i < BANKS; i++) setting[i] <= '0;
    end else begin
      if (state == ST_OUT && (!out.valid || out.ready)) out.valid <= 1'b1;
      else if (out.ready) out.valid <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (CA+1)'(CD - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (in_xfer) begin
          fend_r <= fend_i;
          d <= (func_i == FUNC_FILTER && 32'(bank_i) >= BANKS) ? '0 : samp_i;
          bnk <= BW'(bank_i);
          lvl <= '0;
          if (func_i == FUNC_LOAD) begin
            if (32'(bank_i) < BANKS && 32'(ld_lv) < LEVELS && ld_slot == 3'(SLOT_SET)
                && ld_lv == 5'd0)
              setting[BW'(bank_i)] <= pword_i[SET_W-1:0];
          end else if (32'(bank_i) >= BANKS) begin
            state <= ST_G2;
          end else state <= ST_RD;
        end
        ST_RD: begin term <= 3'd0; state <= ST_RD2; end
        ST_RD2: begin
          {x1, x2, y1, y2} <= h_rd;
          cw <= c_rd; accx <= '0; accy <= '0; state <= ST_MAC;
        end
        ST_MAC: begin
          if (term < 3'd3) accx <= accx + prod; else accy <= accy + prod;
          cw <= c_rd;
          term <= term + 1'b1;
          if (term == 3'd4) state <= ST_LIM;
        end
        ST_LIM: state <= ST_WB;
        ST_WB: begin
          d <= o_val;
          if (lvl == LW'(LEVELS - 1)) state <= ST_G1;
          else begin lvl <= lvl + 1'b1; state <= ST_RD; end
        end
        ST_G1: begin
          d <= 24'(gq);
          state <= ST_G2;
        end
        ST_G2: state <= ST_OUT;
        ST_OUT: if (!out.valid || out.ready) begin
          out.data <= {d, fend_r}; state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // memory port control
  always_comb begin
    c_we = 1'b0; c_wa = '0; c_wd = pword_i;
    h_we = 1'b0; h_wa = hidx; h_wd = {d, x1, yf, y1};
    c_ra = cbase; h_ra = hidx;
    case (state)
      ST_CLR: begin
        c_we = 1'b1; c_wa = CA'(clr_cnt); c_wd = '0;
        h_we = (clr_cnt < (CA+1)'(HD)); h_wa = HA'(clr_cnt); h_wd = '0;
      end
      ST_IDLE: begin
        c_we = in_xfer && func_i == FUNC_LOAD && 32'(bank_i) < BANKS
               && 32'(ld_lv) < LEVELS && ld_slot < 3'(SLOT_SET);
        c_wa = CA'((32'(bank_i) * LEVELS + 32'(ld_lv)) * 8 + 32'(ld_slot));
      end
      ST_RD: c_ra = cbase;
      // read one word ahead so cw holds the coefficient of the current term
      ST_RD2: c_ra = cbase + CA'(1);
      ST_MAC: c_ra = cbase + CA'(term) + CA'(2);
      ST_WB: h_we = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hdl/bbq_ram.sv =====
module bbq_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/bbq_checker.sv =====
module bbq_checker
  import bbq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [SAMPLE_W:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_no_res_on_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out valid after reset");
  a_no_take_rst: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("ready during clear");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("out data changed");
endmodule

bind banked_biquad_cascade_filter_core bbq_checker u_chk (.clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
  .out_ready(out.ready), .out_data(out.data));
